[rtl/core/sgcd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgcd_pkg
// Shared widths and types of the signed 64-bit gcd block.
// ---------------------------------------------------------------------------
package sgcd_pkg;

   localparam int DataWidth  = 64;
   localparam int ShiftWidth = 6;

   typedef logic [DataWidth-1:0]        word_type;
   typedef logic signed [DataWidth-1:0] sword_type;
   typedef logic [ShiftWidth-1:0]       shift_type;

   // queue entry: either a finished value or two magnitudes for the engine
   typedef struct packed {
      logic     general;
      word_type first;
      word_type second;
   } sgcd_entry_type;

   // status between queue and engine
   typedef struct packed {
      logic           head_valid;
      sgcd_entry_type head;
   } sgcd_head_type;

endpackage

[rtl/core/sgcd_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgcd_req_if / sgcd_rsp_if
// Valid/ready channels carrying gcd operands and the gcd result.
// ---------------------------------------------------------------------------
interface sgcd_req_if;
   import sgcd_pkg::*;

   logic      valid;
   logic      ready;
   sword_type operand_a;
   sword_type operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sgcd_rsp_if;
   import sgcd_pkg::*;

   logic      valid;
   logic      ready;
   sword_type divisor;

   modport source (output valid, output divisor, input ready);
   modport sink (input valid, input divisor, output ready);
endinterface

[rtl/core/signed_gcd_64.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_gcd_64
// Greatest common divisor of two signed 64-bit operands.
// ---------------------------------------------------------------------------
// req_if carries operand_a/operand_b; rsp_if returns one divisor per
// transaction, in order. An operand equal to one yields 1; a zero first
// operand returns the second unchanged, a zero second operand the first.
// Otherwise the gcd of the magnitudes is returned as a signed value.
// The front settles those cases and writes a QUEUE_DEPTH-entry queue; it
// keeps taking transactions while the queue has room.
// The engine runs binary gcd, one step per cycle: each step shifts or
// subtracts and shortens one of the two magnitudes by at least one bit,
// until the two are equal; it takes no new transaction before then.
// Special cases go straight from the queue to the output register.
// The result waits in an output register; while it is full, a stalled
// receiver holds back a finished run and any pop; the queue fills behind it.
// A synchronous reset empties the queue and drops any result in flight.
// ---------------------------------------------------------------------------
module signed_gcd_64 #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic        clock,
   input logic        reset,
   sgcd_req_if.sink   req_if,
   sgcd_rsp_if.source rsp_if
);
   import sgcd_pkg::*;

   logic           push;
   sgcd_entry_type push_entry;
   logic           queue_full;
   logic           pop;
   sgcd_head_type  head_status;

   sgcd_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sgcd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .full        (queue_full),
      .pop         (pop),
      .head_status (head_status)
   );

   sgcd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head_status (head_status),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

[rtl/core/sgcd_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgcd_front
// Accepts operand pairs, settles the special cases and forms magnitudes.
// ---------------------------------------------------------------------------
module sgcd_front (
   sgcd_req_if.sink                  req_if,
   input  logic                      queue_full,
   output logic                      push,
   output sgcd_pkg::sgcd_entry_type  push_entry
);
   import sgcd_pkg::*;

   word_type raw_a;
   word_type raw_b;
   word_type mag_a;
   word_type mag_b;

   assign raw_a = word_type'(req_if.operand_a);
   assign raw_b = word_type'(req_if.operand_b);

   // most negative value maps to 2^63, which fits unsigned
   assign mag_a = raw_a[DataWidth-1] ? (~raw_a + word_type'(1)) : raw_a;
   assign mag_b = raw_b[DataWidth-1] ? (~raw_b + word_type'(1)) : raw_b;

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   always_comb begin
      push_entry.general = 1'b0;
      push_entry.first   = raw_a;
      push_entry.second  = mag_b;
      if (raw_a == word_type'(1) || raw_b == word_type'(1)) begin
         push_entry.first = word_type'(1);
      end else if (raw_a == '0) begin
         push_entry.first = raw_b;
      end else if (raw_b == '0) begin
         push_entry.first = raw_a;
      end else begin
         push_entry.general = 1'b1;
         push_entry.first   = mag_a;
      end
   end

endmodule

[rtl/core/sgcd_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgcd_queue
// Small FIFO between the classifying front and the gcd engine.
// ---------------------------------------------------------------------------
module sgcd_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sgcd_pkg::sgcd_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output sgcd_pkg::sgcd_head_type  head_status
);
   import sgcd_pkg::*;

   localparam int AddrWidth  = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   sgcd_entry_type        entry_ff [QUEUE_DEPTH];
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign full    = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign push_ok = push && !full;
   assign pop_ok  = pop && (count_ff != '0);

   assign head_status.head_valid = (count_ff != '0);
   assign head_status.head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AddrWidth'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AddrWidth'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/sgcd_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgcd_engine
// Binary gcd on two magnitudes, one shift or subtract-and-shift step per cycle.
// ---------------------------------------------------------------------------
module sgcd_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  sgcd_pkg::sgcd_head_type  head_status,
   output logic                     pop,
   sgcd_rsp_if.source               rsp_if
);
   import sgcd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type           state_ff;
   word_type            u_ff, v_ff;
   shift_type           shift_ff;
   logic                rsp_valid_ff;
   word_type            divisor_ff;
   logic                out_free;
   logic                finish_now;
   logic [DataWidth:0]  diff_uv;
   word_type            diff_vu;
   logic                u_eq_v;
   logic                u_gt_v;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign pop      = (state_ff == ST_IDLE) && head_status.head_valid && out_free;

   // a result is captured this cycle, either a settled case or a finished run
   assign finish_now = (state_ff == ST_IDLE) ? (pop && !head_status.head.general)
                                             : (u_eq_v && out_free);

   assign diff_uv = {1'b0, u_ff} - {1'b0, v_ff};
   assign diff_vu = v_ff - u_ff;
   assign u_eq_v  = (u_ff == v_ff);
   assign u_gt_v  = !diff_uv[DataWidth] && !u_eq_v;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.divisor = sword_type'(divisor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop && head_status.head.general) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (u_eq_v && out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath: loads, iteration steps and result capture
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         if (pop) begin
            u_ff     <= head_status.head.first;
            v_ff     <= head_status.head.second;
            shift_ff <= '0;
            if (!head_status.head.general) begin
               divisor_ff <= head_status.head.first;
            end
         end
      end else if (u_eq_v) begin
         if (out_free) begin
            divisor_ff <= u_ff << shift_ff;
         end
      end else if (!u_ff[0] && !v_ff[0]) begin
         u_ff     <= u_ff >> 1;
         v_ff     <= v_ff >> 1;
         shift_ff <= shift_ff + 1'b1;
      end else if (!u_ff[0]) begin
         u_ff <= u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_ff <= v_ff >> 1;
      end else if (u_gt_v) begin
         // both odd: the difference is even
         u_ff <= diff_uv[DataWidth:1];
      end else begin
         v_ff <= diff_vu >> 1;
      end
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed 64-bit gcd block.
// ---------------------------------------------------------------------------
// A clocked driver takes operand pairs from a pending queue and offers them
// on the request channel with random gaps. A clocked monitor takes divisors
// from the response channel with random stalls and compares each one with
// the oldest predicted divisor. Directed corner cases come first, then
// random pairs of several shapes; the last stretch runs without idling.
// ---------------------------------------------------------------------------
module tb_top;
   import sgcd_pkg::*;

   localparam int        RANDOM_JOBS   = 1800;
   localparam int        CALM_JOBS     = 200;
   localparam int        DRAIN_EVERY   = 300;
   localparam int        IDLE_LIMIT    = 4000;
   localparam int        TAIL_CYCLES   = 300;
   localparam int        REPORT_LIMIT  = 10;
   localparam sword_type MOST_NEG      = 64'sh8000_0000_0000_0000;
   localparam sword_type MOST_POS      = 64'sh7fff_ffff_ffff_ffff;
   localparam sword_type FIB_91        = 64'sd4660046610375530309;
   localparam sword_type FIB_92        = 64'sd7540113804746346429;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_SHARED,
      SHAPE_SHIFTED,
      SHAPE_TINY,
      SHAPE_MIRROR,
      SHAPE_EXTREME
   } pair_shape_type;

   typedef struct {
      sword_type operand_a;
      sword_type operand_b;
      bit        drain_first;
      bit        calm;
   } gcd_job_type;

   logic clock;
   logic reset;

   sgcd_req_if req_bus ();
   sgcd_rsp_if rsp_bus ();

   signed_gcd_64 uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   gcd_job_type pending_jobs[$];
   sword_type   expected_divisors[$];

   int total_jobs      = 0;
   int directed_jobs   = 0;
   int accepted_jobs   = 0;
   int checked_results = 0;
   int nontrivial_gcds = 0;
   int error_count     = 0;
   int gap_left        = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;
   bit calm_phase      = 0;

   always #5 clock = ~clock;

   // divisor the block must return for one operand pair
   function automatic sword_type expected_divisor(sword_type a, sword_type b);
      word_type mag_a;
      word_type mag_b;
      word_type lo;
      word_type hi;
      word_type rem;
      if (a == 1 || b == 1)
         return 1;
      if (a == 0)
         return b;
      if (b == 0)
         return a;
      mag_a = a;
      mag_b = b;
      if (mag_a[DataWidth-1])
         mag_a = ~mag_a + 1'b1;
      if (mag_b[DataWidth-1])
         mag_b = ~mag_b + 1'b1;
      lo = (mag_a < mag_b) ? mag_a : mag_b;
      hi = (mag_a < mag_b) ? mag_b : mag_a;
      while (lo != 0) begin
         rem = hi % lo;
         hi  = lo;
         lo  = rem;
      end
      return sword_type'(hi);
   endfunction

   function automatic sword_type random_word();
      return sword_type'({$urandom, $urandom});
   endfunction

   function automatic sword_type random_sign(sword_type v);
      return ($urandom_range(0, 1) == 1) ? -v : v;
   endfunction

   task automatic queue_job(input sword_type a, input sword_type b,
                            input bit drain_first = 0, input bit calm = 0);
      gcd_job_type job;
      job.operand_a   = a;
      job.operand_b   = b;
      job.drain_first = drain_first;
      job.calm        = calm;
      pending_jobs.push_back(job);
      total_jobs++;
   endtask

   task automatic queue_random_job(input bit drain_first, input bit calm);
      pair_shape_type shape;
      sword_type      a;
      sword_type      b;
      sword_type      factor;
      sword_type      picks[7];
      int             roll;
      picks = '{MOST_NEG, MOST_POS, 0, 1, -1, MOST_NEG + 1, 2};
      roll  = $urandom_range(0, 9);
      case (roll)
         0, 1, 2, 3: shape = SHAPE_WIDE;
         4, 5:       shape = SHAPE_SHARED;
         6:          shape = SHAPE_SHIFTED;
         7:          shape = SHAPE_TINY;
         8:          shape = SHAPE_MIRROR;
         default:    shape = SHAPE_EXTREME;
      endcase
      case (shape)
         SHAPE_WIDE: begin
            a = random_word();
            b = random_word();
         end
         SHAPE_SHARED: begin
            // common factor so the gcd is usually well above one
            factor = sword_type'($urandom_range(1, 1 << 20));
            a = random_sign(factor * (random_word() >>> 0 & 64'h0000_00ff_ffff_ffff));
            b = random_sign(factor * (random_word() >>> 0 & 64'h0000_00ff_ffff_ffff));
         end
         SHAPE_SHIFTED: begin
            a = (random_word() | 64'sd1) <<< $urandom_range(0, 63);
            b = (random_word() | 64'sd1) <<< $urandom_range(0, 63);
         end
         SHAPE_TINY: begin
            a = sword_type'($urandom_range(0, 40)) - 20;
            b = sword_type'($urandom_range(0, 40)) - 20;
         end
         SHAPE_MIRROR: begin
            a = random_word();
            case ($urandom_range(0, 2))
               0:       b = a;
               1:       b = -a;
               default: b = a * sword_type'($urandom_range(2, 9));
            endcase
         end
         default: begin
            a = picks[$urandom_range(0, 6)];
            b = ($urandom_range(0, 1) == 1) ? picks[$urandom_range(0, 6)] : random_word();
            if ($urandom_range(0, 1) == 1) begin
               factor = a;
               a      = b;
               b      = factor;
            end
         end
      endcase
      queue_job(a, b, drain_first, calm);
   endtask

   // request side: one nonblocking write per signal per edge
   always @(posedge clock) begin
      sword_type predicted;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = expected_divisor(req_bus.operand_a, req_bus.operand_b);
            expected_divisors.push_back(predicted);
            accepted_jobs = accepted_jobs + 1;
            if (predicted > 1)
               nontrivial_gcds = nontrivial_gcds + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_jobs.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (pending_jobs[0].drain_first && expected_divisors.size() != 0) begin
               // hold off until every outstanding divisor is back
               req_bus.valid <= 1'b0;
            end else if (!pending_jobs[0].calm && $urandom_range(0, 9) == 0) begin
               gap_left      <= $urandom_range(0, 13);
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid     <= 1'b1;
               req_bus.operand_a <= pending_jobs[0].operand_a;
               req_bus.operand_b <= pending_jobs[0].operand_b;
               calm_phase        <= pending_jobs[0].calm;
               void'(pending_jobs.pop_front());
            end
         end
      end
   end

   // response side: random stall bursts, compare against oldest prediction
   always @(posedge clock) begin
      sword_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_divisors.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: unexpected divisor %0d", $realtime, rsp_bus.divisor);
               error_count = error_count + 1;
            end else begin
               want = expected_divisors.pop_front();
               checked_results = checked_results + 1;
               if (rsp_bus.divisor !== want) begin
                  if (error_count < REPORT_LIMIT)
                     $display("%0t: divisor mismatch, expected %0d got %0d",
                              $realtime, want, rsp_bus.divisor);
                  error_count = error_count + 1;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(0, 13);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      rsp_bus.ready     = 1'b0;

      // directed corners
      queue_job(1, MOST_NEG);
      queue_job(MOST_POS, 1);
      queue_job(1, 1);
      queue_job(1, 0);
      queue_job(0, 1);
      queue_job(0, 0);
      queue_job(0, -5);
      queue_job(0, MOST_NEG);
      queue_job(7, 0);
      queue_job(MOST_NEG, 0);
      queue_job(MOST_POS, 0);
      queue_job(-1, 0);
      queue_job(-1, -1);
      queue_job(-1, MOST_POS);
      queue_job(MOST_NEG, MOST_NEG);
      queue_job(MOST_NEG, MOST_POS);
      queue_job(MOST_POS, MOST_POS);
      queue_job(MOST_NEG, -(64'sd1 <<< 62));
      queue_job(-12, 18);
      queue_job(12, -18);
      queue_job(FIB_91, FIB_92);
      queue_job(MOST_POS, MOST_POS - 1);
      queue_job(64'sd1 <<< 62, 64'sd3 <<< 61);
      queue_job(-64'sd6, MOST_NEG);
      directed_jobs = total_jobs;

      for (int i = 0; i < RANDOM_JOBS; i++)
         queue_random_job(i % DRAIN_EVERY == 0, i >= RANDOM_JOBS - CALM_JOBS);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_jobs < total_jobs)
         @(posedge clock);
      while (expected_divisors.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_divisors.size() != 0) begin
         $display("%0d divisors never returned", expected_divisors.size());
         error_count = error_count + expected_divisors.size();
      end
      $display("ran %0d operand pairs (%0d directed, %0d random), %0d divisors checked",
               accepted_jobs, directed_jobs, accepted_jobs - directed_jobs, checked_results);
      $display("%0d results had a gcd above one, %0d errors", nontrivial_gcds, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
